>>> design/config_text_tokenizer_top_defines.svh
// -----------------------------------------------------------------------------
// config_text_tokenizer_top_defines: assertion macros
// Shared helpers for the concurrent checks in the tokenizer modules.
// -----------------------------------------------------------------------------
`ifndef CONFIG_TEXT_TOKENIZER_TOP_DEFINES_SVH
`define CONFIG_TEXT_TOKENIZER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ctt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ctt: next-cycle check failed");

`endif

>>> design/ctt_pkg.sv
// -----------------------------------------------------------------------------
// ctt_pkg: tokenizer package
// Character constants, scan modes, token kinds and byte classification.
// -----------------------------------------------------------------------------
package ctt_pkg;

    // Default width of offsets and lengths.
    localparam int CTT_OFFSET_BITS = 20;

    // Depth of the queue between scanner and output stage (power of two).
    localparam int CTT_QUEUE_DEPTH = 4;

    // Token kind codes.
    localparam int KIND_BITS = 3;
    localparam logic [KIND_BITS-1:0] KIND_IDENT   = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_COMMENT = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_PUNCT   = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_END     = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_ERROR   = 3'd5;

    // Scan mode codes.
    localparam int MODE_BITS = 2;
    localparam logic [MODE_BITS-1:0] MODE_IDLE    = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_IDENT   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_COMMENT = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_NUMBER  = 2'd3;

    // Characters with a special meaning.
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c == CH_LBRACE || c == CH_RBRACE || c == CH_COLON ||
               c == CH_DOT || c == CH_SLASH;
    endfunction

    // True when the byte extends a token that is open in the given mode.
    function automatic logic continues(input logic [MODE_BITS-1:0] mode,
                                       input logic [7:0] c);
        logic result;
        case (mode)
            MODE_IDENT:   result = is_letter(c) || is_digit(c) || c == CH_UNDERSCORE;
            MODE_COMMENT: result = c != CH_NEWLINE && c != CH_NUL;
            MODE_NUMBER:  result = is_digit(c) || c == CH_DOT;
            default:      result = 1'b0;
        endcase
        return result;
    endfunction

    function automatic logic [KIND_BITS-1:0] kind_of_mode(input logic [MODE_BITS-1:0] mode);
        logic [KIND_BITS-1:0] kind;
        case (mode)
            MODE_IDENT:   kind = KIND_IDENT;
            MODE_COMMENT: kind = KIND_COMMENT;
            default:      kind = KIND_NUMBER;
        endcase
        return kind;
    endfunction

endpackage

>>> design/ctt_byte_if.sv
// -----------------------------------------------------------------------------
// ctt_byte_if: text byte channel
// Valid/ready channel that carries one text byte per request.
// -----------------------------------------------------------------------------
interface ctt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

>>> design/ctt_token_if.sv
// -----------------------------------------------------------------------------
// ctt_token_if: token channel
// Valid/ready channel that carries one token per request.
// -----------------------------------------------------------------------------
interface ctt_token_if #(
    parameter int OFFSET_BITS = ctt_pkg::CTT_OFFSET_BITS
);
    logic                         valid;
    logic                         ready;
    logic [ctt_pkg::KIND_BITS-1:0] token_kind;
    logic [OFFSET_BITS-1:0]       token_start;
    logic [OFFSET_BITS-1:0]       token_length;
    logic                         last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input last_of_run, output ready);
endinterface

>>> design/ctt_front.sv
// -----------------------------------------------------------------------------
// ctt_front: byte scanner
// Accepts text bytes, tracks the open token and offset, and pushes the one or
// two tokens that a byte produces into the queue as a single entry.
// -----------------------------------------------------------------------------
`include "config_text_tokenizer_top_defines.svh"

module ctt_front #(
    parameter int OFFSET_BITS = ctt_pkg::CTT_OFFSET_BITS,
    parameter int PAIR_BITS   = 1 + 2 * (ctt_pkg::KIND_BITS + 2 * OFFSET_BITS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ctt_byte_if.sink             i_text,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output logic [PAIR_BITS-1:0] o_push_data
);
    import ctt_pkg::*;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] length;
    } t_token;

    typedef struct packed {
        logic   two;
        t_token first;
        t_token second;
    } t_pair;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    logic [MODE_BITS-1:0]   r_mode,   n_mode;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [OFFSET_BITS-1:0] r_start,  n_start;

    logic                   accept;
    logic [7:0]             c;
    logic [OFFSET_BITS-1:0] off_inc;
    logic                   have_close;
    t_token                 close_tok;
    logic                   have_new;
    t_token                 new_tok;
    t_pair                  pair;

    assign i_text.ready = !i_queue_full;
    assign accept       = i_text.valid && !i_queue_full;
    assign c            = i_text.text_byte;
    assign off_inc      = (r_offset == OFF_MAX) ? r_offset : r_offset + 1'b1;

    // Scanner next state and the tokens produced by this byte.
    always_comb begin
        n_mode     = r_mode;
        n_offset   = r_offset;
        n_start    = r_start;
        have_close = 1'b0;
        close_tok  = '0;
        have_new   = 1'b0;
        new_tok    = '0;
        if (accept) begin
            if (r_mode != MODE_IDLE && continues(r_mode, c)) begin
                n_offset = off_inc;
            end else begin
                // A byte that ends the open token closes it first.
                if (r_mode != MODE_IDLE) begin
                    have_close       = 1'b1;
                    close_tok.kind   = kind_of_mode(r_mode);
                    close_tok.start  = r_start;
                    close_tok.length = r_offset - r_start;
                    n_mode           = MODE_IDLE;
                end
                // Then the byte is handled as in idle mode.
                if (c == CH_NUL) begin
                    have_new       = 1'b1;
                    new_tok.kind   = KIND_END;
                    new_tok.start  = r_offset;
                    new_tok.length = '0;
                    n_offset       = '0;
                end else begin
                    if (is_space(c)) begin
                        have_new = 1'b0;
                    end else if (is_letter(c)) begin
                        n_mode  = MODE_IDENT;
                        n_start = r_offset;
                    end else if (c == CH_HASH) begin
                        n_mode  = MODE_COMMENT;
                        n_start = r_offset;
                    end else if (c == CH_MINUS || is_digit(c)) begin
                        n_mode  = MODE_NUMBER;
                        n_start = r_offset;
                    end else begin
                        have_new       = 1'b1;
                        new_tok.kind   = is_punct(c) ? KIND_PUNCT : KIND_ERROR;
                        new_tok.start  = r_offset;
                        new_tok.length = OFFSET_BITS'(1);
                    end
                    n_offset = off_inc;
                end
            end
        end
    end

    // Pack the produced tokens into one queue entry.
    always_comb begin
        pair = '0;
        if (have_close) begin
            pair.first  = close_tok;
            pair.second = new_tok;
            pair.two    = have_new;
        end else begin
            pair.first  = new_tok;
        end
    end

    assign o_push      = have_close || have_new;
    assign o_push_data = pair;

    // Scanner state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_offset <= '0;
            r_start  <= '0;
        end else begin
            r_mode   <= n_mode;
            r_offset <= n_offset;
            r_start  <= n_start;
        end
    end

    `CTT_ASSERT_NEXT(a_end_rewinds, i_clk, i_rst_n, accept && c == CH_NUL, r_offset == '0 && r_mode == MODE_IDLE)
    `CTT_ASSERT_NEXT(a_offset_sticks, i_clk, i_rst_n, accept && c != CH_NUL && r_offset == OFF_MAX, r_offset == OFF_MAX)
    `CTT_ASSERT_SAME(a_start_behind, i_clk, i_rst_n, r_mode != MODE_IDLE, r_start <= r_offset)

endmodule

>>> design/ctt_queue.sv
// -----------------------------------------------------------------------------
// ctt_queue: token pair queue
// Short register FIFO between the scanner and the output stage.
// -----------------------------------------------------------------------------
`include "config_text_tokenizer_top_defines.svh"

module ctt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ctt_pkg::CTT_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output logic             o_empty
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(DEPTH);
    localparam logic [PTR_BITS-1:0] LAST_PTR  = PTR_BITS'(DEPTH - 1);

    logic [WIDTH-1:0]    r_slot [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                do_push, do_pop;

    assign o_full     = r_count == DEPTH_CNT;
    assign o_empty    = r_count == '0;
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_data = r_slot[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `CTT_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_CNT)

endmodule

>>> design/ctt_back.sv
// -----------------------------------------------------------------------------
// ctt_back: token output stage
// Takes queue entries and sends their tokens one per request through an
// output register, marking the final token of each byte.
// -----------------------------------------------------------------------------
`include "config_text_tokenizer_top_defines.svh"

module ctt_back #(
    parameter int OFFSET_BITS = ctt_pkg::CTT_OFFSET_BITS,
    parameter int PAIR_BITS   = 1 + 2 * (ctt_pkg::KIND_BITS + 2 * OFFSET_BITS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_queue_empty,
    input  logic [PAIR_BITS-1:0] i_pop_data,
    output logic                 o_pop,
    ctt_token_if.source          o_token
);
    import ctt_pkg::*;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] length;
    } t_token;

    typedef struct packed {
        logic   two;
        t_token first;
        t_token second;
    } t_pair;

    t_pair  head;
    logic   load;

    logic   r_valid, n_valid;
    logic   r_pend,  n_pend;
    t_token r_out,   n_out;
    logic   r_last,  n_last;
    t_token r_held,  n_held;

    assign head = i_pop_data;
    assign load = !r_valid || o_token.ready;

    // Choose what enters the output register.
    always_comb begin
        n_valid = r_valid;
        n_pend  = r_pend;
        n_out   = r_out;
        n_last  = r_last;
        n_held  = r_held;
        o_pop   = 1'b0;
        if (load) begin
            if (r_pend) begin
                n_out   = r_held;
                n_last  = 1'b1;
                n_pend  = 1'b0;
                n_valid = 1'b1;
            end else if (!i_queue_empty) begin
                n_out   = head.first;
                n_last  = !head.two;
                n_held  = head.second;
                n_pend  = head.two;
                n_valid = 1'b1;
                o_pop   = 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_last <= n_last;
        r_held <= n_held;
    end

    assign o_token.valid        = r_valid;
    assign o_token.token_kind   = r_out.kind;
    assign o_token.token_start  = r_out.start;
    assign o_token.token_length = r_out.length;
    assign o_token.last_of_run  = r_last;

    `CTT_ASSERT_SAME(a_held_behind_out, i_clk, i_rst_n, r_pend, r_valid && !r_last)

endmodule

>>> design/config_text_tokenizer_top.sv
// -----------------------------------------------------------------------------
// config_text_tokenizer_top: configuration text tokenizer
// Splits a byte stream into identifier, comment, punctuation, number, end and
// error tokens, each reported with start offset and length.
// -----------------------------------------------------------------------------
// The block takes one text byte per cycle as long as its four-entry token
// queue has room, and sends at most one token per cycle. A byte that closes a
// token and is also a token of its own yields two tokens, which leave one
// after the other; so the sustained rate is one byte per cycle until the
// output port, at one token per cycle, becomes the limit. A token is written
// into a queue entry and then into the output register before it appears at
// the output. Offsets saturate at 2**OFFSET_BITS - 1 and return to zero
// after a zero byte, which also emits an end token.

module config_text_tokenizer_top #(
    parameter int OFFSET_BITS = ctt_pkg::CTT_OFFSET_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ctt_byte_if.sink     i_text,
    ctt_token_if.source  o_token
);
    import ctt_pkg::*;

    localparam int PAIR_BITS = 1 + 2 * (KIND_BITS + 2 * OFFSET_BITS);

    logic                 queue_full;
    logic                 queue_empty;
    logic                 push;
    logic                 pop;
    logic [PAIR_BITS-1:0] push_data;
    logic [PAIR_BITS-1:0] pop_data;

    // Scanner: accepts bytes and produces token entries.
    ctt_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .PAIR_BITS   (PAIR_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text       (i_text),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    // Queue that decouples the scanner from the output port.
    ctt_queue #(
        .WIDTH (PAIR_BITS),
        .DEPTH (CTT_QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (queue_empty)
    );

    // Output stage: one token per request.
    ctt_back #(
        .OFFSET_BITS (OFFSET_BITS),
        .PAIR_BITS   (PAIR_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_empty (queue_empty),
        .i_pop_data    (pop_data),
        .o_pop         (pop),
        .o_token       (o_token)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_top: tokenizer testbench
// Streams text bytes into the tokenizer and checks every token against a
// cycle-free model of the scanner. There is a directed opening, then random
// config-like text under four idle/stall mixes, then a short directed tail.
// -----------------------------------------------------------------------------

module tb_top;
    import ctt_pkg::*;

    // One token as it leaves the block.
    typedef struct packed {
        logic [KIND_BITS-1:0]       kind;
        logic [CTT_OFFSET_BITS-1:0] start;
        logic [CTT_OFFSET_BITS-1:0] length;
        logic                       last;
    } t_token;

    // Shadow of the scanner state plus the tokens still owed by the block.
    class token_shadow;
        logic [MODE_BITS-1:0]       mode;
        logic [CTT_OFFSET_BITS-1:0] offset;
        logic [CTT_OFFSET_BITS-1:0] open_start;
        t_token                     pending[$];
        int unsigned                fails;

        function new();
            mode       = MODE_IDLE;
            offset     = '0;
            open_start = '0;
            fails      = 0;
        endfunction

        static function bit alpha(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        static function bit numeral(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        static function bit blank(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        static function bit single_punct(logic [7:0] c);
            return c == CH_LBRACE || c == CH_RBRACE || c == CH_COLON ||
                   c == CH_DOT || c == CH_SLASH;
        endfunction

        // True when the byte extends the token that is currently open.
        function bit keeps_token(logic [7:0] c);
            case (mode)
                MODE_IDENT:   return alpha(c) || numeral(c) || c == CH_UNDERSCORE;
                MODE_COMMENT: return c != CH_NEWLINE && c != CH_NUL;
                MODE_NUMBER:  return numeral(c) || c == CH_DOT;
                default:      return 1'b0;
            endcase
        endfunction

        // The offset sticks at its maximum until the next zero byte.
        function void advance();
            if (offset != '1)
                offset++;
        endfunction

        function void push_token(logic [KIND_BITS-1:0] kind,
                                 logic [CTT_OFFSET_BITS-1:0] start,
                                 logic [CTT_OFFSET_BITS-1:0] len);
            t_token t;
            t.kind   = kind;
            t.start  = start;
            t.length = len;
            t.last   = 1'b0;
            pending.push_back(t);
        endfunction

        // Scan one accepted byte and queue the tokens it produces.
        function void note_byte(logic [7:0] c);
            int unsigned          queued;
            logic [KIND_BITS-1:0] closed_kind;
            queued = pending.size();
            if (mode != MODE_IDLE) begin
                if (keeps_token(c)) begin
                    advance();
                    return;
                end
                case (mode)
                    MODE_IDENT:   closed_kind = KIND_IDENT;
                    MODE_COMMENT: closed_kind = KIND_COMMENT;
                    default:      closed_kind = KIND_NUMBER;
                endcase
                push_token(closed_kind, open_start, offset - open_start);
                mode = MODE_IDLE;
            end
            if (c == CH_NUL) begin
                push_token(KIND_END, offset, '0);
                offset = '0;
            end else begin
                if (alpha(c)) begin
                    mode       = MODE_IDENT;
                    open_start = offset;
                end else if (c == CH_HASH) begin
                    mode       = MODE_COMMENT;
                    open_start = offset;
                end else if (c == CH_MINUS || numeral(c)) begin
                    mode       = MODE_NUMBER;
                    open_start = offset;
                end else if (single_punct(c)) begin
                    push_token(KIND_PUNCT, offset, CTT_OFFSET_BITS'(1));
                end else if (!blank(c)) begin
                    push_token(KIND_ERROR, offset, CTT_OFFSET_BITS'(1));
                end
                advance();
            end
            if (pending.size() > queued)
                pending[$].last = 1'b1;
        endfunction

        task report(string msg);
            fails++;
            if (fails <= 40)
                $display("token mismatch: %s", msg);
        endtask

        // Compare a received token with the oldest one owed.
        task check_token(t_token got);
            t_token want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected token kind %0d start %0d length %0d",
                                 got.kind, got.start, got.length));
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.start !== want.start)
                report($sformatf("start %0d, want %0d", got.start, want.start));
            if (got.length !== want.length)
                report($sformatf("length %0d, want %0d", got.length, want.length));
            if (got.last !== want.last)
                report($sformatf("last_of_run %0b, want %0b", got.last, want.last));
        endtask
    endclass

    localparam int unsigned CYCLE_LIMIT    = 200_000;
    localparam int unsigned TAIL_CYCLES    = 10;
    localparam int unsigned RANDOM_BYTES   = 125;

    logic i_clk;
    logic i_rst_n;

    ctt_byte_if                                     text_if();
    ctt_token_if #(.OFFSET_BITS(CTT_OFFSET_BITS))   token_if();

    config_text_tokenizer_top #(
        .OFFSET_BITS(CTT_OFFSET_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_if),
        .o_token (token_if)
    );

    token_shadow shadow;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned bytes_sent;
    int unsigned cycle_count = 0;

    string letter_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
    string ident_set  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
    string number_set = "01234567890123456789.";
    string punct_set  = "{}:./";
    string blank_set  = " \t\n\013\014\r";

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[config_text_tokenizer_top] ERROR");
            $finish;
        end
    end

    // Token side back-pressure, redrawn every cycle.
    always @(negedge i_clk) begin
        token_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each token the block hands over.
    always @(posedge i_clk) begin : token_monitor
        t_token got;
        if (i_rst_n && token_if.valid && token_if.ready) begin
            got.kind   = token_if.token_kind;
            got.start  = token_if.token_start;
            got.length = token_if.token_length;
            got.last   = token_if.last_of_run;
            shadow.check_token(got);
        end
    end

    function automatic logic [7:0] pick_char(string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    // Offer one byte, with a random gap first, and wait for it to be taken.
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            text_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        text_if.valid     <= 1'b1;
        text_if.text_byte <= b;
        @(posedge i_clk);
        while (!text_if.ready)
            @(posedge i_clk);
        shadow.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Stop offering bytes until every owed token has arrived.
    task automatic pause_until_drained();
        @(negedge i_clk);
        text_if.valid <= 1'b0;
        while (shadow.pending.size() != 0)
            @(posedge i_clk);
    endtask

    // One random piece of config-like text; mostly well-formed, some noise.
    task automatic send_fragment();
        case ($urandom_range(11))
            0, 1, 2: begin
                send_byte(pick_char(letter_set));
                repeat ($urandom_range(6)) send_byte(pick_char(ident_set));
            end
            3, 4: begin
                // A minus with nothing after it is still a number.
                if ($urandom_range(2) == 0)
                    send_byte(CH_MINUS);
                else
                    send_byte(pick_char("0123456789"));
                repeat ($urandom_range(5)) send_byte(pick_char(number_set));
            end
            5: begin
                send_byte(CH_HASH);
                repeat ($urandom_range(8)) send_byte(8'($urandom_range(1, 255)));
                send_byte(($urandom_range(3) == 0) ? CH_NUL : CH_NEWLINE);
            end
            6, 7: send_byte(pick_char(punct_set));
            8, 9: repeat ($urandom_range(1, 3)) send_byte(pick_char(blank_set));
            10:   send_byte(CH_NUL);
            default: send_byte(8'($urandom_range(255)));
        endcase
    endtask

    task automatic random_text(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned phase_end;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        phase_end      = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < phase_end)
            send_fragment();
    endtask

    // Stimulus sequence.
    initial begin
        shadow             = new();
        i_rst_n            = 1'b0;
        text_if.valid      = 1'b0;
        text_if.text_byte  = '0;
        token_if.ready     = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        bytes_sent         = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: every token kind, bytes above 127 in and out of
        // a comment, a lone minus, a comment closed by a zero byte, and an
        // identifier closed by punctuation.
        send_text("ab_9{-1.2:#");
        send_byte(8'hFF);
        send_text("x\n- #c");
        send_byte(CH_NUL);
        send_text("$");
        send_byte(8'h80);
        send_text("z./}");
        send_byte(CH_NUL);

        random_text(0, 0);
        pause_until_drained();
        repeat (4) @(posedge i_clk);
        random_text(69, 0);
        random_text(0, 69);
        random_text(31, 31);
        pause_until_drained();

        // Short directed tail: tokens closed by a newline, by a space and by
        // a zero byte, then a fresh text after the offset returns to zero.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_byte(CH_NUL);
        send_text("#c\nab{-7 x");
        send_byte(CH_NUL);
        send_text("q:");
        send_byte(CH_NUL);

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (shadow.fails == 0)
            $display("[config_text_tokenizer_top] OK");
        else
            $display("[config_text_tokenizer_top] ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/ctt_pkg.sv
design/ctt_byte_if.sv
design/ctt_token_if.sv
design/ctt_front.sv
design/ctt_queue.sv
design/ctt_back.sv
design/config_text_tokenizer_top.sv
tb/sv/tb_top.sv
